@@ rtl/rgb_to_hsv_convert_defines.svh @@
// rgb_to_hsv_convert_defines.svh: assertion macros for the rgb to hsv converter
// no dependencies; taken in by the checker with `include
`ifndef RGB_TO_HSV_CONVERT_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_DEFINES_SVH

// concurrent check on i_clk, switched off while reset is held
`define RHC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// concurrent check on i_clk that also runs through reset
`define RHC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/rhc_pkg.sv @@
// rhc_pkg: widths, hue constants, pipeline types and the divider step
// no dependencies; imported by every module of the rgb to hsv converter
package rhc_pkg;

    localparam int COMP_W       = 8;
    localparam int HUE_W        = 15;
    localparam int HUE_QW       = 12;
    localparam int DIV_STEPS    = (HUE_QW > COMP_W) ? HUE_QW : COMP_W;
    localparam int IN_DATA_W    = ((3 * COMP_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = HUE_W + 2 * COMP_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int PROD_H_W     = HUE_QW + COMP_W;
    localparam int PROD_S_W     = 2 * COMP_W;

    // one sixth of a turn, and the sector bases, in 1/64 degree
    localparam logic [HUE_QW-1:0] HUE_SIXTH      = HUE_QW'(3840);
    localparam logic [HUE_W-1:0]  HUE_GREEN_BASE = HUE_W'(7680);
    localparam logic [HUE_W-1:0]  HUE_BLUE_BASE  = HUE_W'(15360);
    localparam logic [HUE_W-1:0]  HUE_FULL       = HUE_W'(23040);
    localparam logic [COMP_W-1:0] COMP_FULL      = '1;

    // which component is the maximum
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    typedef struct packed {
        logic [1:0]        sector;
        logic              grey;
        logic              black;
        logic              neg;
        logic [COMP_W-1:0] maxc;
        logic [COMP_W-1:0] delta;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [COMP_W-1:0] mag;
    } t_front;

    // remainder and shifting numerator/quotient word for each lane
    typedef struct packed {
        logic [COMP_W-1:0] rem_h;
        logic [HUE_QW-1:0] quo_h;
        logic [COMP_W-1:0] rem_s;
        logic [COMP_W-1:0] quo_s;
    } t_div;

    typedef struct packed {
        t_side side;
        t_div  div;
    } t_div_item;

    typedef struct packed {
        logic [COMP_W-1:0] rem;
        logic              qbit;
    } t_step;

    // one restoring division step; remainder stays below the divisor
    function automatic t_step div_step(input logic [COMP_W-1:0] rem,
                                       input logic              bit_in,
                                       input logic [COMP_W-1:0] divisor);
        logic [COMP_W:0] trial;
        t_step           res;
        trial = {rem, bit_in};
        if (trial >= {1'b0, divisor}) begin
            res.rem  = COMP_W'(trial - {1'b0, divisor});
            res.qbit = 1'b1;
        end else begin
            res.rem  = trial[COMP_W-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

@@ rtl/rhc_div_pipe.sv @@
// rhc_div_pipe: pipelined restoring divider, one quotient bit per stage, two lanes
// depends on rhc_pkg (t_div_item, div_step, DIV_STEPS)
module rhc_div_pipe
    import rhc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_div_item i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_div_item o_out_item
);

    logic [DIV_STEPS-1:0] r_vld;
    t_div_item            r_item [DIV_STEPS];
    t_div_item            n_item [DIV_STEPS];
    logic [DIV_STEPS:0]   stage_rdy;
    logic [DIV_STEPS-1:0] prev_vld;
    t_div_item            prev_item [DIV_STEPS];

    assign stage_rdy[DIV_STEPS] = i_out_ready;

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_stage
        t_step step_h;
        t_step step_s;

        if (s == 0) begin : g_first
            assign prev_vld[s]  = i_in_valid;
            assign prev_item[s] = i_in_item;
        end else begin : g_next
            assign prev_vld[s]  = r_vld[s-1];
            assign prev_item[s] = r_item[s-1];
        end

        // a stage takes a new item when empty or when its content moves on
        assign stage_rdy[s] = !r_vld[s] || stage_rdy[s+1];

        assign step_h = div_step(prev_item[s].div.rem_h, prev_item[s].div.quo_h[HUE_QW-1],
                                 prev_item[s].side.delta);
        assign step_s = div_step(prev_item[s].div.rem_s, prev_item[s].div.quo_s[COMP_W-1],
                                 prev_item[s].side.maxc);

        always_comb begin
            n_item[s] = prev_item[s];
            if (s < HUE_QW) begin
                n_item[s].div.rem_h = step_h.rem;
                n_item[s].div.quo_h = {prev_item[s].div.quo_h[HUE_QW-2:0], step_h.qbit};
            end
            if (s < COMP_W) begin
                n_item[s].div.rem_s = step_s.rem;
                n_item[s].div.quo_s = {prev_item[s].div.quo_s[COMP_W-2:0], step_s.qbit};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (stage_rdy[s]) begin
                r_vld[s] <= prev_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (stage_rdy[s] && prev_vld[s]) begin
                r_item[s] <= n_item[s];
            end
        end
    end

    assign o_in_ready  = stage_rdy[0];
    assign o_out_valid = r_vld[DIV_STEPS-1];
    assign o_out_item  = r_item[DIV_STEPS-1];

endmodule

@@ rtl/rgb_to_hsv_convert.sv @@
// rgb_to_hsv_convert: top level of the pixel rgb to hsv converter
// depends on rhc_pkg and rhc_div_pipe
//
// usage
//   slave stream: one rgb pixel per transfer on i_s_axis_tdata, red in the
//   lowest byte, then green, then blue.
//   master stream: one hsv result per pixel, in pixel order, on
//   o_m_axis_tdata: hue (15 bits, 1/64 degree), saturation, brightness.
//   pipeline: the max/min stage, the constant product stage, 12 divider stages (one
//   quotient bit each, set by the 12-bit hue quotient) and the output register.
//   throughput: one pixel per cycle, sustained with no gaps while i_m_axis_tready is high.
//   stalls: every stage holds its item while the next is full and blocked;
//   empty stages keep filling, so up to 15 pixels are taken while the
//   receiver holds i_m_axis_tready low, and none is lost or repeated.
//   reset: synchronous, active low; all valid bits clear, the pipeline comes
//   out empty and o_s_axis_tready is high on the first cycle after it.
//   the block keeps no state between pixels and has no registers to set.
module rgb_to_hsv_convert
    import rhc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // red, green, blue from bit 0 up
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // hue, saturation, brightness from bit 0 up, zero padded
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic [COMP_W-1:0] red, green, blue;
    logic [COMP_W-1:0] op_a, op_b, min_rg, minc;
    t_front            front;
    logic              r_a_vld, a_rdy;
    t_front            r_a;
    logic              r_b_vld, b_rdy;
    t_div_item         r_b;
    t_div_item         n_b;
    logic [PROD_H_W-1:0] prod_h;
    logic [PROD_S_W-1:0] prod_s;
    logic              div_in_rdy, div_out_vld, out_rdy;
    t_div_item         div_out;
    logic [HUE_W-1:0]  quo_ext, n_hue;
    logic [COMP_W-1:0] n_sat;
    logic              r_o_vld;
    logic [HUE_W-1:0]  r_hue;
    logic [COMP_W-1:0] r_sat, r_bri;

    assign red   = i_s_axis_tdata[COMP_W-1:0];
    assign green = i_s_axis_tdata[2*COMP_W-1:COMP_W];
    assign blue  = i_s_axis_tdata[3*COMP_W-1:2*COMP_W];

    // stage a: maximum, minimum, sector and the signed component difference
    always_comb begin
        front = '0;
        op_a  = '0;
        op_b  = '0;
        priority if (red >= green && red >= blue) begin
            front.side.sector = SEC_RED;
            front.side.maxc   = red;
            op_a = green;
            op_b = blue;
        end else if (green >= blue) begin
            front.side.sector = SEC_GREEN;
            front.side.maxc   = green;
            op_a = blue;
            op_b = red;
        end else begin
            front.side.sector = SEC_BLUE;
            front.side.maxc   = blue;
            op_a = red;
            op_b = green;
        end
        min_rg = (green < red) ? green : red;
        minc   = (blue < min_rg) ? blue : min_rg;
        front.side.delta = front.side.maxc - minc;
        front.side.grey  = (front.side.delta == '0);
        front.side.black = (front.side.maxc == '0);
        front.side.neg   = (op_a < op_b);
        front.mag        = front.side.neg ? (op_b - op_a) : (op_a - op_b);
    end

    assign b_rdy           = !r_b_vld || div_in_rdy;
    assign a_rdy           = !r_a_vld || b_rdy;
    assign o_s_axis_tready = a_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (a_rdy) begin
            r_a_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy && i_s_axis_tvalid) begin
            r_a <= front;
        end
    end

    // stage b: numerators; quotients fit the low bits so the high bits seed the remainder
    assign prod_h = PROD_H_W'(HUE_SIXTH) * PROD_H_W'(r_a.mag);
    assign prod_s = PROD_S_W'(COMP_FULL) * PROD_S_W'(r_a.side.delta);

    always_comb begin
        n_b           = '0;
        n_b.side      = r_a.side;
        n_b.div.rem_h = prod_h[PROD_H_W-1:HUE_QW];
        n_b.div.quo_h = prod_h[HUE_QW-1:0];
        n_b.div.rem_s = prod_s[PROD_S_W-1:COMP_W];
        n_b.div.quo_s = prod_s[COMP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (b_rdy) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_rdy && r_a_vld) begin
            r_b <= n_b;
        end
    end

    rhc_div_pipe u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (r_b_vld),
        .o_in_ready  (div_in_rdy),
        .i_in_item   (r_b),
        .o_out_valid (div_out_vld),
        .i_out_ready (out_rdy),
        .o_out_item  (div_out)
    );

    // output stage: place the quotient in its sector
    assign quo_ext = HUE_W'(div_out.div.quo_h);

    always_comb begin
        unique case (div_out.side.sector)
            SEC_RED: begin
                n_hue = (div_out.side.neg && quo_ext != '0) ? (HUE_FULL - quo_ext) : quo_ext;
            end
            SEC_GREEN: begin
                n_hue = div_out.side.neg ? (HUE_GREEN_BASE - quo_ext)
                                         : (HUE_GREEN_BASE + quo_ext);
            end
            SEC_BLUE: begin
                n_hue = div_out.side.neg ? (HUE_BLUE_BASE - quo_ext)
                                         : (HUE_BLUE_BASE + quo_ext);
            end
            default: begin
                n_hue = '0;
            end
        endcase
        // grey pixels divide by zero, the quotient is meaningless there
        if (div_out.side.grey) begin
            n_hue = '0;
        end
        n_sat = div_out.side.black ? '0 : div_out.div.quo_s;
    end

    assign out_rdy = !r_o_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_rdy) begin
            r_o_vld <= div_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && div_out_vld) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_bri <= div_out.side.maxc;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, r_bri, r_sat, r_hue};

endmodule

@@ rtl/rhc_checker.sv @@
// rhc_checker: port level checks on the rgb to hsv converter, bound to the top level
// depends on rhc_pkg and rgb_to_hsv_convert_defines.svh
`include "rgb_to_hsv_convert_defines.svh"

module rhc_checker
    import rhc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic [HUE_W-1:0]  hue;
    logic [COMP_W-1:0] sat;
    logic [COMP_W-1:0] bri;
    logic              stalled;

    assign hue     = o_m_axis_tdata[HUE_W-1:0];
    assign sat     = o_m_axis_tdata[HUE_W+COMP_W-1:HUE_W];
    assign bri     = o_m_axis_tdata[HUE_W+2*COMP_W-1:HUE_W+COMP_W];
    assign stalled = o_m_axis_tvalid && !i_m_axis_tready;

    // reset empties the pipeline
    `RHC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

    // a held result keeps its data
    `RHC_ASSERT(a_hold, stalled |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "held data changed")

    // hue wraps below a full turn
    `RHC_ASSERT(a_hue_range, o_m_axis_tvalid |-> hue < HUE_FULL, "hue out of range")

    // black has neither hue nor saturation
    `RHC_ASSERT(a_black, o_m_axis_tvalid && bri == '0 |-> sat == '0 && hue == '0, "black with colour")

endmodule

bind rgb_to_hsv_convert rhc_checker u_rhc_checker (.*);

@@ dv/testbench.sv @@
// testbench: self-checking bench for the rgb to hsv pixel converter
// depends on rhc_pkg and rgb_to_hsv_convert; predicts every hsv result and
// checks the output stream against it under varied stream idling and stalls
module testbench
    import rhc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_LEN   = 11;
    localparam int PHASE_ITEMS = 170;
    localparam int DRAIN_WAIT  = 20;
    localparam int HOLD_LEN    = 60;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [COMP_W-1:0] sat;
        logic [COMP_W-1:0] bright;
    } t_hsv;

    // expected hsv results in pixel order and the checks against them
    class hsv_board;
        t_hsv pending_hsv[$];
        int   errors;
        int   pixels;
        int   results;

        function automatic int hue_step(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b,
                                        logic [COMP_W-1:0] span);
            // signed int division truncates toward zero
            return (int'(HUE_SIXTH) * (int'(a) - int'(b))) / int'(span);
        endfunction

        function automatic t_hsv hsv_of_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                                              logic [COMP_W-1:0] b);
            logic [COMP_W-1:0] hi;
            logic [COMP_W-1:0] lo;
            logic [COMP_W-1:0] span;
            int                h;
            t_hsv              res;
            hi = r;
            lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            span = hi - lo;
            h = 0;
            if (span != 0) begin
                // ties go to red first, then green
                if (hi == r) begin
                    h = hue_step(g, b, span);
                    if (h < 0) h += int'(HUE_FULL);
                end else if (hi == g) begin
                    h = int'(HUE_GREEN_BASE) + hue_step(b, r, span);
                end else begin
                    h = int'(HUE_BLUE_BASE) + hue_step(r, g, span);
                end
            end
            res.hue    = h[HUE_W-1:0];
            res.sat    = (hi == 0) ? '0 : COMP_W'((int'(COMP_FULL) * int'(span)) / int'(hi));
            res.bright = hi;
            return res;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] error: %s", $time, what);
            errors++;
        endtask

        function void note_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                                 logic [COMP_W-1:0] b);
            pending_hsv.push_back(hsv_of_pixel(r, g, b));
            pixels++;
        endfunction

        task check_result(logic [OUT_DATA_W-1:0] data);
            t_hsv want;
            t_hsv got;
            got.hue    = data[HUE_W-1:0];
            got.sat    = data[HUE_W +: COMP_W];
            got.bright = data[HUE_W+COMP_W +: COMP_W];
            results++;
            if (pending_hsv.size() == 0) begin
                report_mismatch($sformatf("unexpected result transfer %h", data));
                return;
            end
            want = pending_hsv.pop_front();
            if (got.hue != want.hue)
                report_mismatch($sformatf("result %0d hue %0d, expected %0d",
                                          results, got.hue, want.hue));
            if (got.sat != want.sat)
                report_mismatch($sformatf("result %0d saturation %0d, expected %0d",
                                          results, got.sat, want.sat));
            if (got.bright != want.bright)
                report_mismatch($sformatf("result %0d brightness %0d, expected %0d",
                                          results, got.bright, want.bright));
        endtask

        function int pending();
            return pending_hsv.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // red, green, blue from bit 0 up
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // hue, saturation, brightness from bit 0 up, zero padded
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    logic    long_stall = 1'b0;
    hsv_board board = new();

    rgb_to_hsv_convert DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // output side: random back-pressure, or a long hold when asked
    always @(posedge i_clk) begin
        if (long_stall)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(o_m_axis_tdata);
    end

    // holds the output off for the given number of clock cycles while the input keeps going
    task automatic hold_output(int cycles);
        long_stall <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        long_stall <= 1'b0;
    endtask

    task automatic send_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                              logic [COMP_W-1:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_DATA_W'({b, g, r});
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_pixel(r, g, b);
    endtask

    // input goes quiet until every expected result has been seen
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // mostly uniform colours, with greys, tied maxima and near-black mixed in
    task automatic send_random_pixel();
        logic [COMP_W-1:0] c[3];
        logic [COMP_W-1:0] m;
        m = COMP_W'($urandom_range(255));
        case ($urandom_range(7))
            0: c = '{m, m, m};
            1: begin
                c = '{m, m, m};
                c[$urandom_range(2)] = COMP_W'($urandom_range(int'(m)));
            end
            2: foreach (c[k]) c[k] = COMP_W'($urandom_range(3));
            default: foreach (c[k]) c[k] = COMP_W'($urandom());
        endcase
        send_pixel(c[0], c[1], c[2]);
    endtask

    initial begin
        // red, green, blue from the top byte down
        logic [23:0] corner_pixels[] = '{
            24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000,
            24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
            24'hFF0001, 24'hFF0100, 24'h01FF00, 24'h00FF01, 24'h0100FF,
            24'h0001FF, 24'h010000, 24'h000001, 24'hFEFF00, 24'h7F80FF,
            24'hFF7F00, 24'h8000FF, 24'h0A0B0C, 24'hF0F1EF
        };
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_pixels[k])
            send_pixel(corner_pixels[k][23:16], corner_pixels[k][15:8],
                       corner_pixels[k][7:0]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 49; end
                default: begin send_idle_pct = 32; recv_stall_pct <= 32; end
            endcase
            if (phase == 0) begin
                fork
                    hold_output(HOLD_LEN);
                join_none
            end
            repeat (PHASE_ITEMS) send_random_pixel();
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d expected results never arrived",
                                            board.pending()));
        $display("covered %0d pixels (corners, greys, ties, near-black, random) and %0d results",
                 board.pixels, board.results);
        $display("under free flow, input gaps, output stalls, both, and a long output hold");
        if (board.errors == 0)
            $display("rgb_to_hsv_convert: match");
        else
            $display("rgb_to_hsv_convert: mismatch");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting on the output stream");
        $display("rgb_to_hsv_convert: mismatch");
        $finish;
    end

endmodule
